// File: rtl/core/brc_pkg.sv
// ============================================================================
// brc_pkg
// Shared types and constants of the balance robot cascade controller:
// register indexes, reset values, step codes and controller interface.
// ============================================================================
package brc_pkg;

    localparam int A_W = 26;
    localparam int G_W = 28;
    localparam int P_W = A_W + G_W;

    typedef enum logic [2:0] {
        CFG_MODE         = 3'd0,
        CFG_ANGLE_TARGET = 3'd1,
        CFG_ANGLE_P      = 3'd2,
        CFG_ANGLE_D      = 3'd3,
        CFG_SPEED_P      = 3'd4,
        CFG_SPEED_I      = 3'd5,
        CFG_TURN_P       = 3'd6,
        CFG_TURN_D       = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        STEP_ANG_P = 3'd0,
        STEP_ANG_D = 3'd1,
        STEP_FILT  = 3'd2,
        STEP_SPD_P = 3'd3,
        STEP_SPD_I = 3'd4,
        STEP_TRN_P = 3'd5,
        STEP_TRN_D = 3'd6
    } t_step;

    typedef enum logic [1:0] {
        SH_16 = 2'd0,
        SH_22 = 2'd1,
        SH_24 = 2'd2
    } t_shift;

    typedef struct packed {
        logic  load;
        logic  mul;
        logic  acc;
        logic  mix;
        t_step step;
    } t_brc_cmd;

    typedef struct packed {
        logic out_free;
    } t_brc_stat;

    localparam logic              RST_MODE         = 1'b0;
    localparam logic signed [16:0] RST_ANGLE_TARGET = 17'sd640;
    localparam logic signed [27:0] RST_ANGLE_P      = -28'sd13107200;
    localparam logic signed [27:0] RST_ANGLE_D      = -28'sd26214;
    localparam logic signed [27:0] RST_SPEED_P      = -28'sd3276800;
    localparam logic signed [27:0] RST_SPEED_I      = -28'sd16384;
    localparam logic signed [27:0] RST_TURN_P       = 28'sd655360;
    localparam logic signed [27:0] RST_TURN_D       = 28'sd0;

    localparam logic signed [16:0] TILT_LIMIT  = 17'sd10240;
    localparam logic signed [18:0] INTEG_LIMIT = 19'sd10000;
    localparam logic signed [19:0] DEAD_OFFSET = 20'sd200;
    // ceil(2^22 / 5): exact quotient by five for magnitudes below 2^22
    localparam logic signed [27:0] DIV5_MUL    = 28'sd838861;

endpackage

// File: rtl/core/brc_mul.sv
// ============================================================================
// brc_mul
// Shared signed multiplier with registered product, followed by a scale
// stage that truncates toward zero and saturates to 16 bits.
// ============================================================================
module brc_mul
    import brc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [A_W-1:0] i_a,
    input  logic signed [G_W-1:0] i_g,
    input  t_shift                i_shift,
    output logic signed [15:0]    o_term
);

    logic signed [P_W-1:0] r_prod;
    t_shift                r_shift;
    logic signed [P_W-1:0] prod;
    logic signed [P_W-1:0] bias;
    logic signed [P_W-1:0] adj;
    logic signed [P_W-1:0] q;

    assign prod = i_a * i_g;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= prod;
            r_shift <= i_shift;
        end
    end

    always_comb begin
        unique case (r_shift)
            SH_16:   bias = r_prod[P_W-1] ? P_W'(65535)    : '0;
            SH_22:   bias = r_prod[P_W-1] ? P_W'(4194303)  : '0;
            SH_24:   bias = r_prod[P_W-1] ? P_W'(16777215) : '0;
            default: bias = '0;
        endcase
        adj = r_prod + bias;
        unique case (r_shift)
            SH_16:   q = adj >>> 16;
            SH_22:   q = adj >>> 22;
            SH_24:   q = adj >>> 24;
            default: q = adj;
        endcase
        if (q > P_W'(32767)) begin
            o_term = 16'sh7fff;
        end else if (q < -P_W'(32768)) begin
            o_term = -16'sh8000;
        end else begin
            o_term = q[15:0];
        end
    end

endmodule

// File: rtl/core/brc_ctrl.sv
// ============================================================================
// brc_ctrl
// Sequencer: takes an item, runs seven multiply and accumulate passes,
// then mixes into the output register once it is free.
// ============================================================================
module brc_ctrl
    import brc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_brc_stat i_stat,
    output t_brc_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_MIX
    } t_state;

    t_state r_state;
    t_step  r_step;
    logic   r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step     <= STEP_ANG_P;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= ST_MUL;
                        r_step     <= STEP_ANG_P;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_step == STEP_TRN_D) begin
                        r_state <= ST_MIX;
                    end else begin
                        r_step  <= t_step'(r_step + 3'd1);
                        r_state <= ST_MUL;
                    end
                end
                ST_MIX: begin
                    if (i_stat.out_free) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_cmd.load  = r_in_ready & i_in_valid;
    assign o_cmd.mul   = (r_state == ST_MUL);
    assign o_cmd.acc   = (r_state == ST_ACC);
    assign o_cmd.mix   = (r_state == ST_MIX) & i_stat.out_free;
    assign o_cmd.step  = r_step;

endmodule

// File: rtl/core/brc_datapath.sv
// ============================================================================
// brc_datapath
// Configuration registers, loop state, operand selection for the shared
// multiplier, loop accumulators, output mixing and the output register.
// ============================================================================
module brc_datapath
    import brc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_brc_cmd           i_cmd,
    output t_brc_stat          o_stat,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [27:0]        i_cfg_data,
    input  logic signed [16:0] i_tilt_angle,
    input  logic signed [15:0] i_pitch_rate,
    input  logic signed [15:0] i_yaw_rate,
    input  logic signed [15:0] i_left_count,
    input  logic signed [15:0] i_right_count,
    input  logic signed [15:0] i_speed_target,
    input  logic signed [15:0] i_turn_target,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [17:0] o_left_drive,
    output logic signed [17:0] o_right_drive,
    output logic               o_tipped_over
);

    function automatic logic signed [17:0] offset_drive(input logic signed [18:0] v);
        logic signed [19:0] w;
        w = (v > 19'sd0) ? (20'(v) + DEAD_OFFSET) : (20'(v) - DEAD_OFFSET);
        if (w > 20'sd131071) begin
            return 18'sh1ffff;
        end else if (w < -20'sd131072) begin
            return -18'sh20000;
        end
        return w[17:0];
    endfunction

    logic               r_mode;
    logic signed [16:0] r_angle_target;
    logic signed [27:0] r_angle_p;
    logic signed [27:0] r_angle_d;
    logic signed [27:0] r_speed_p;
    logic signed [27:0] r_speed_i;
    logic signed [27:0] r_turn_p;
    logic signed [27:0] r_turn_d;

    logic signed [15:0] r_filt;
    logic signed [14:0] r_integ;
    logic signed [16:0] r_last;

    logic signed [A_W-1:0] r_err;
    logic signed [18:0]    r_fx;
    logic signed [15:0]    r_pitch;
    logic signed [15:0]    r_yaw;
    logic signed [15:0]    r_turn_tgt;
    logic                  r_tipped;

    logic signed [16:0] r_angle;
    logic signed [16:0] r_speed;
    logic signed [16:0] r_turn;

    logic               r_out_valid;
    logic signed [17:0] r_left;
    logic signed [17:0] r_right;
    logic               r_tip_out;

    logic                  tipped_in;
    logic signed [A_W-1:0] last_sh;
    logic signed [A_W-1:0] err_in;
    logic signed [17:0]    e_in;
    logic signed [18:0]    fx_in;
    logic signed [18:0]    integ_sum;
    logic signed [14:0]    integ_in;
    logic signed [A_W-1:0] mul_a;
    logic signed [G_W-1:0] mul_g;
    t_shift                mul_sh;
    logic signed [15:0]    term;
    logic signed [16:0]    term_ext;
    logic signed [18:0]    left_mix;
    logic signed [18:0]    right_mix;

    // load: error terms and the new integral
    always_comb begin
        tipped_in = (i_tilt_angle > TILT_LIMIT) || (i_tilt_angle < -TILT_LIMIT);
        last_sh   = {r_last[16], r_last, 8'd0};
        err_in    = A_W'(r_angle_target) - A_W'(i_tilt_angle) + (r_mode ? last_sh : '0);
        e_in      = 18'(i_speed_target) - (18'(i_left_count) + 18'(i_right_count));
        fx_in     = 19'(e_in) + (19'(r_filt) <<< 2);
        integ_sum = 19'(r_integ) + 19'(e_in);
        if (tipped_in) begin
            integ_in = '0;
        end else if (integ_sum > INTEG_LIMIT) begin
            integ_in = 15'(INTEG_LIMIT);
        end else if (integ_sum < -INTEG_LIMIT) begin
            integ_in = 15'(-INTEG_LIMIT);
        end else begin
            integ_in = integ_sum[14:0];
        end
    end

    // operand select
    always_comb begin
        unique case (i_cmd.step)
            STEP_ANG_P: begin
                mul_a = r_err;              mul_g = r_angle_p; mul_sh = SH_24;
            end
            STEP_ANG_D: begin
                mul_a = A_W'(r_pitch);      mul_g = r_angle_d; mul_sh = SH_16;
            end
            STEP_FILT: begin
                mul_a = A_W'(r_fx);         mul_g = DIV5_MUL;  mul_sh = SH_22;
            end
            STEP_SPD_P: begin
                mul_a = A_W'(r_filt);       mul_g = r_speed_p; mul_sh = SH_16;
            end
            STEP_SPD_I: begin
                mul_a = A_W'(r_integ);      mul_g = r_speed_i; mul_sh = SH_16;
            end
            STEP_TRN_P: begin
                mul_a = A_W'(r_turn_tgt);   mul_g = r_turn_p;  mul_sh = SH_16;
            end
            STEP_TRN_D: begin
                mul_a = A_W'(r_yaw);        mul_g = r_turn_d;  mul_sh = SH_16;
            end
            default: begin
                mul_a = '0;                 mul_g = '0;        mul_sh = SH_16;
            end
        endcase
    end

    brc_mul u_mul (
        .i_clk   (i_clk),
        .i_en    (i_cmd.mul),
        .i_a     (mul_a),
        .i_g     (mul_g),
        .i_shift (mul_sh),
        .o_term  (term)
    );

    assign term_ext  = 17'(term);
    assign left_mix  = 19'(r_angle) - 19'(r_turn) + (r_mode ? 19'sd0 : 19'(r_speed));
    assign right_mix = 19'(r_angle) + 19'(r_turn) + (r_mode ? 19'sd0 : 19'(r_speed));

    // configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= RST_MODE;
            r_angle_target <= RST_ANGLE_TARGET;
            r_angle_p      <= RST_ANGLE_P;
            r_angle_d      <= RST_ANGLE_D;
            r_speed_p      <= RST_SPEED_P;
            r_speed_i      <= RST_SPEED_I;
            r_turn_p       <= RST_TURN_P;
            r_turn_d       <= RST_TURN_D;
            r_filt         <= '0;
            r_integ        <= '0;
            r_last         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MODE:         r_mode         <= i_cfg_data[0];
                    CFG_ANGLE_TARGET: r_angle_target <= i_cfg_data[16:0];
                    CFG_ANGLE_P:      r_angle_p      <= i_cfg_data;
                    CFG_ANGLE_D:      r_angle_d      <= i_cfg_data;
                    CFG_SPEED_P:      r_speed_p      <= i_cfg_data;
                    CFG_SPEED_I:      r_speed_i      <= i_cfg_data;
                    CFG_TURN_P:       r_turn_p       <= i_cfg_data;
                    CFG_TURN_D:       r_turn_d       <= i_cfg_data;
                    default:          r_mode         <= r_mode;
                endcase
            end
            if (i_cmd.load) begin
                r_integ <= integ_in;
            end
            if (i_cmd.acc && (i_cmd.step == STEP_FILT)) begin
                r_filt <= term;
            end
            if (i_cmd.mix) begin
                r_last      <= r_speed;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err      <= err_in;
            r_fx       <= fx_in;
            r_pitch    <= i_pitch_rate;
            r_yaw      <= i_yaw_rate;
            r_turn_tgt <= i_turn_target;
            r_tipped   <= tipped_in;
        end
        if (i_cmd.acc) begin
            unique case (i_cmd.step)
                STEP_ANG_P: r_angle <= term_ext;
                STEP_ANG_D: r_angle <= r_angle + term_ext;
                STEP_FILT:  r_speed <= r_speed;
                STEP_SPD_P: r_speed <= term_ext;
                STEP_SPD_I: r_speed <= r_speed + term_ext;
                STEP_TRN_P: r_turn  <= term_ext;
                STEP_TRN_D: r_turn  <= r_turn + term_ext;
                default:    r_turn  <= r_turn;
            endcase
        end
        if (i_cmd.mix) begin
            r_left    <= r_tipped ? 18'sd0 : offset_drive(left_mix);
            r_right   <= r_tipped ? 18'sd0 : offset_drive(right_mix);
            r_tip_out <= r_tipped;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_left_drive    = r_left;
    assign o_right_drive   = r_right;
    assign o_tipped_over   = r_tip_out;

endmodule

// File: rtl/core/balance_robot_cascade_controller.sv
// Each item is loaded, then taken through seven passes of the single shared
// multiplier, each a multiply state and an accumulate state, and then mixed;
// no new item is taken until the mix, which waits for a free output register.
// A finished result waits in the output register while the next item is taken.
// Reset (i_rst_n low, synchronous) restores register defaults and clears the
// speed filter, integral and last speed output.
// ============================================================================
// balance_robot_cascade_controller
// Angle PD, speed PI and turn PD cascade for a two-wheel balancing robot,
// built as a sequencer driving a shared multiply and scale datapath.
// ============================================================================
module balance_robot_cascade_controller
    import brc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [16:0] i_tilt_angle,
    input  logic signed [15:0] i_pitch_rate,
    input  logic signed [15:0] i_yaw_rate,
    input  logic signed [15:0] i_left_count,
    input  logic signed [15:0] i_right_count,
    input  logic signed [15:0] i_speed_target,
    input  logic signed [15:0] i_turn_target,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [17:0] o_left_drive,
    output logic signed [17:0] o_right_drive,
    output logic               o_tipped_over,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [27:0]        i_cfg_data
);

    t_brc_cmd  cmd;
    t_brc_stat stat;

    assign o_cfg_ready = 1'b1;

    brc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    brc_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_tilt_angle   (i_tilt_angle),
        .i_pitch_rate   (i_pitch_rate),
        .i_yaw_rate     (i_yaw_rate),
        .i_left_count   (i_left_count),
        .i_right_count  (i_right_count),
        .i_speed_target (i_speed_target),
        .i_turn_target  (i_turn_target),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_left_drive   (o_left_drive),
        .o_right_drive  (o_right_drive),
        .o_tipped_over  (o_tipped_over)
    );

    a_tip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tipped_over |-> o_left_drive == 18'sd0 && o_right_drive == 18'sd0)
        else $error("tipped result carries nonzero drive");

    a_drive_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tipped_over |-> o_left_drive != 18'sd0 && o_right_drive != 18'sd0)
        else $error("upright result carries zero drive");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item taken while previous item still in work");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.mul, cmd.acc, cmd.mix}))
        else $error("overlapping datapath commands");

endmodule

// File: test/brc_drive_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// brc_drive_checker
// Watches the tick, drive and register channels of the cascade controller,
// predicts both motor drives and the tip-over flag for every accepted tick
// and compares them, in order, with the drives the controller hands out.
// ============================================================================
module brc_drive_checker
    import brc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [16:0] i_tilt_angle,
    input  logic signed [15:0] i_pitch_rate,
    input  logic signed [15:0] i_yaw_rate,
    input  logic signed [15:0] i_left_count,
    input  logic signed [15:0] i_right_count,
    input  logic signed [15:0] i_speed_target,
    input  logic signed [15:0] i_turn_target,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [17:0] i_left_drive,
    input  logic signed [17:0] i_right_drive,
    input  logic               i_tipped_over,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [27:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_outstanding
);

    localparam longint TIP_LIMIT  = 10240;
    localparam longint WIND_LIMIT = 10000;
    localparam longint DEADBAND   = 200;
    localparam longint DRIVE_MAX  = 131071;
    localparam longint DRIVE_MIN  = -131072;
    localparam longint Q16        = 65536;
    localparam longint Q24        = 16777216;

    typedef struct packed {
        logic signed [17:0] left;
        logic signed [17:0] right;
        logic               tipped;
    } t_drive;

    logic   fold_speed;
    longint tgt_angle;
    longint kp_angle;
    longint kd_angle;
    longint kp_speed;
    longint ki_speed;
    longint kp_turn;
    longint kd_turn;
    longint filt_err;
    longint wind;
    longint prev_speed;
    t_drive due_drives[$];
    t_drive want;
    int     n_ticks = 0;
    int     n_drives = 0;
    int     mismatches = 0;

    assign o_errors      = mismatches;
    assign o_outstanding = n_ticks - n_drives;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint gain_term(input longint a, input longint g, input longint div);
        return clip((a * g) / div, -32768, 32767);
    endfunction

    function automatic logic signed [17:0] with_deadband(input longint v);
        longint r;
        r = (v > 0) ? v + DEADBAND : v - DEADBAND;
        return 18'(clip(r, DRIVE_MIN, DRIVE_MAX));
    endfunction

    function automatic t_drive balance_step();
        longint tilt;
        longint err;
        longint e;
        longint ang;
        longint spd;
        longint trn;
        longint lft;
        longint rgt;
        t_drive d;
        tilt = i_tilt_angle;
        d.tipped = (tilt > TIP_LIMIT) || (tilt < -TIP_LIMIT);
        err = tgt_angle - tilt;
        if (fold_speed) begin
            err += prev_speed * 256;
        end
        ang = gain_term(err, kp_angle, Q24) + gain_term(i_pitch_rate, kd_angle, Q16);
        e = longint'(i_speed_target) - (longint'(i_left_count) + longint'(i_right_count));
        filt_err = clip((e + 4 * filt_err) / 5, -32768, 32767);
        wind = d.tipped ? 0 : clip(wind + e, -WIND_LIMIT, WIND_LIMIT);
        spd = gain_term(filt_err, kp_speed, Q16) + gain_term(wind, ki_speed, Q16);
        prev_speed = spd;
        trn = gain_term(i_turn_target, kp_turn, Q16) + gain_term(i_yaw_rate, kd_turn, Q16);
        lft = fold_speed ? ang - trn : ang + spd - trn;
        rgt = fold_speed ? ang + trn : ang + spd + trn;
        d.left  = d.tipped ? '0 : with_deadband(lft);
        d.right = d.tipped ? '0 : with_deadband(rgt);
        return d;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fold_speed = 1'b0;
            tgt_angle  = 640;
            kp_angle   = -13107200;
            kd_angle   = -26214;
            kp_speed   = -3276800;
            ki_speed   = -16384;
            kp_turn    = 655360;
            kd_turn    = 0;
            filt_err   = 0;
            wind       = 0;
            prev_speed = 0;
            due_drives.delete();
            n_ticks    <= 0;
            n_drives   <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MODE:         fold_speed = i_cfg_data[0];
                    CFG_ANGLE_TARGET: tgt_angle  = longint'($signed(i_cfg_data[16:0]));
                    CFG_ANGLE_P:      kp_angle   = longint'($signed(i_cfg_data));
                    CFG_ANGLE_D:      kd_angle   = longint'($signed(i_cfg_data));
                    CFG_SPEED_P:      kp_speed   = longint'($signed(i_cfg_data));
                    CFG_SPEED_I:      ki_speed   = longint'($signed(i_cfg_data));
                    CFG_TURN_P:       kp_turn    = longint'($signed(i_cfg_data));
                    CFG_TURN_D:       kd_turn    = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                due_drives.push_back(balance_step());
                n_ticks <= n_ticks + 1;
            end
            if (i_out_valid && i_out_ready) begin
                n_drives <= n_drives + 1;
                if (due_drives.size() == 0) begin
                    $error("drive item with no tick waiting for it");
                    mismatches++;
                end else begin
                    want = due_drives.pop_front();
                    if (i_left_drive !== want.left) begin
                        $error("left_drive: expected %0d, got %0d", want.left, i_left_drive);
                        mismatches++;
                    end
                    if (i_right_drive !== want.right) begin
                        $error("right_drive: expected %0d, got %0d", want.right, i_right_drive);
                        mismatches++;
                    end
                    if (i_tipped_over !== want.tipped) begin
                        $error("tipped_over: expected %0d, got %0d", want.tipped, i_tipped_over);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

// File: test/tb_balance_robot_cascade_controller.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_balance_robot_cascade_controller
// Drives control ticks through the cascade controller under several gain and
// mode settings: directed corner ticks first, then random ticks with random
// gaps and stalls on both sides, one long output stall and drained pauses.
// A checker beside the controller predicts and compares every drive item.
// ============================================================================
module tb_balance_robot_cascade_controller;
    import brc_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int GAIN_MAX      = 134217727;
    localparam int GAIN_MIN      = -134217728;

    typedef struct packed {
        logic signed [16:0] tilt;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] lc;
        logic signed [15:0] rc;
        logic signed [15:0] sp;
        logic signed [15:0] tn;
    } t_tick;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic signed [16:0] i_tilt_angle   = '0;
    logic signed [15:0] i_pitch_rate   = '0;
    logic signed [15:0] i_yaw_rate     = '0;
    logic signed [15:0] i_left_count   = '0;
    logic signed [15:0] i_right_count  = '0;
    logic signed [15:0] i_speed_target = '0;
    logic signed [15:0] i_turn_target  = '0;
    logic               i_out_ready    = 1'b0;
    logic               i_cfg_valid    = 1'b0;
    logic [2:0]         i_cfg_index    = '0;
    logic [27:0]        i_cfg_data     = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [17:0] o_left_drive;
    logic signed [17:0] o_right_drive;
    logic               o_tipped_over;
    logic               o_cfg_ready;

    logic calm      = 1'b0;
    int   hold_reqs = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   quiet     = 0;
    int   mismatches;
    int   outstanding;

    balance_robot_cascade_controller dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_tilt_angle   (i_tilt_angle),
        .i_pitch_rate   (i_pitch_rate),
        .i_yaw_rate     (i_yaw_rate),
        .i_left_count   (i_left_count),
        .i_right_count  (i_right_count),
        .i_speed_target (i_speed_target),
        .i_turn_target  (i_turn_target),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_left_drive   (o_left_drive),
        .o_right_drive  (o_right_drive),
        .o_tipped_over  (o_tipped_over),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    brc_drive_checker drive_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_tilt_angle   (i_tilt_angle),
        .i_pitch_rate   (i_pitch_rate),
        .i_yaw_rate     (i_yaw_rate),
        .i_left_count   (i_left_count),
        .i_right_count  (i_right_count),
        .i_speed_target (i_speed_target),
        .i_turn_target  (i_turn_target),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_left_drive   (o_left_drive),
        .i_right_drive  (o_right_drive),
        .i_tipped_over  (o_tipped_over),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (mismatches),
        .o_outstanding  (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("tb_balance_robot_cascade_controller: FAIL");
            $finish;
        end
    end

    function automatic t_tick make_tick(input int tilt, pitch, yaw, lc, rc, sp, tn);
        t_tick t;
        t.tilt  = 17'(tilt);
        t.pitch = 16'(pitch);
        t.yaw   = 16'(yaw);
        t.lc    = 16'(lc);
        t.rc    = 16'(rc);
        t.sp    = 16'(sp);
        t.tn    = 16'(tn);
        return t;
    endfunction

    function automatic int corner16();
        case ($urandom_range(4))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic int small_gain();
        return int'($urandom_range(1 << 21)) - (1 << 20);
    endfunction

    function automatic t_tick random_tick();
        int unsigned pick;
        int          tilt;
        pick = $urandom_range(99);
        if (pick < 55) begin
            return make_tick($urandom_range(24000) - 12000, $urandom, $urandom,
                             $urandom_range(600) - 300, $urandom_range(600) - 300,
                             $urandom_range(6000) - 3000, $urandom_range(4000) - 2000);
        end
        if (pick < 90) begin
            return make_tick($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
        end
        case ($urandom_range(7))
            0:       tilt = 65535;
            1:       tilt = -65536;
            2:       tilt = 46080;
            3:       tilt = -46080;
            4:       tilt = 10240;
            5:       tilt = -10241;
            6:       tilt = -10240;
            default: tilt = 10241;
        endcase
        return make_tick(tilt, corner16(), corner16(), corner16(), corner16(),
                         corner16(), corner16());
    endfunction

    task automatic put_tick(input t_tick t);
        if (!calm && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_tilt_angle   <= t.tilt;
        i_pitch_rate   <= t.pitch;
        i_yaw_rate     <= t.yaw;
        i_left_count   <= t.lc;
        i_right_count  <= t.rc;
        i_speed_target <= t.sp;
        i_turn_target  <= t.tn;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic run_ticks(input int n);
        repeat (n) put_tick(random_tick());
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 28'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input int md, tgt, ap, ad, sp, si, tp, td);
        write_reg(CFG_MODE, md);
        write_reg(CFG_ANGLE_TARGET, tgt);
        write_reg(CFG_ANGLE_P, ap);
        write_reg(CFG_ANGLE_D, ad);
        write_reg(CFG_SPEED_P, sp);
        write_reg(CFG_SPEED_I, si);
        write_reg(CFG_TURN_P, tp);
        write_reg(CFG_TURN_D, td);
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero command first, while filter and integral are still clear
        put_tick(make_tick(640, 0, 0, 0, 0, 0, 0));
        put_tick(make_tick(10240, 32767, 0, 0, 0, 0, 0));
        put_tick(make_tick(10241, 0, 0, 0, 0, 0, 0));
        put_tick(make_tick(-10240, -32768, 0, 0, 0, 0, 0));
        put_tick(make_tick(-10241, 0, 0, 0, 0, 0, 0));
        put_tick(make_tick(46080, 0, 0, 0, 0, 0, 0));
        put_tick(make_tick(-46080, 0, 0, 0, 0, 0, 0));
        put_tick(make_tick(65535, 0, 0, 0, 0, 0, 0));
        put_tick(make_tick(-65536, 0, 0, 0, 0, 0, 0));
        put_tick(make_tick(0, 0, 0, -32768, -32768, 32767, 0));
        put_tick(make_tick(0, 0, 0, -32768, -32768, 32767, 0));
        put_tick(make_tick(0, 0, 0, 32767, 32767, -32768, 0));
        put_tick(make_tick(0, 0, 0, 32767, 32767, -32768, 0));
        put_tick(make_tick(0, 0, 32767, 0, 0, 0, 32767));
        put_tick(make_tick(0, 0, -32768, 0, 0, 0, -32768));
        drain();

        load_settings(1, RST_ANGLE_TARGET, RST_ANGLE_P, RST_ANGLE_D, RST_SPEED_P,
                      RST_SPEED_I, RST_TURN_P, RST_TURN_D);
        run_ticks(75);
        drain();

        // push the right drive past the positive rail
        load_settings(0, 46080, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        put_tick(make_tick(-10240, 32767, 32767, -32768, -32768, 32767, 32767));
        put_tick(make_tick(-10240, 32767, 32767, -32768, -32768, 32767, 32767));
        run_ticks(70);
        drain();

        // fold a saturated speed output into the angle error, left drive to the negative rail
        load_settings(1, -46080, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN);
        put_tick(make_tick(10240, 32767, -32768, 32767, 32767, -32768, -32768));
        put_tick(make_tick(10240, 32767, -32768, 32767, 32767, -32768, -32768));
        run_ticks(70);
        drain();

        calm <= 1'b1;
        load_settings($urandom_range(1), $urandom_range(24000) - 12000, small_gain(),
                      small_gain(), small_gain(), small_gain(), small_gain(), small_gain());
        run_ticks(75);
        drain();

        calm <= 1'b0;
        load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        run_ticks(25);
        hold_reqs <= hold_reqs + 1;
        run_ticks(50);
        drain();

        load_settings(0, RST_ANGLE_TARGET, RST_ANGLE_P, RST_ANGLE_D, RST_SPEED_P,
                      RST_SPEED_I, RST_TURN_P, RST_TURN_D);
        run_ticks(75);
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_balance_robot_cascade_controller: PASS");
        end else begin
            $display("tb_balance_robot_cascade_controller: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/brc_pkg.sv
rtl/core/brc_mul.sv
rtl/core/brc_ctrl.sv
rtl/core/brc_datapath.sv
rtl/core/balance_robot_cascade_controller.sv
test/brc_drive_checker.sv
test/tb_balance_robot_cascade_controller.sv
